// ===== rtl/core/gdd_pkg.sv =====
// Shared types and constants for the gaze depth to disparity converter.
package gdd_pkg;

	localparam int ROW_WIDTH_DEF = 2048;
	localparam int COL_W         = 11;
	localparam int DEPTH_W       = 8;
	localparam int DISP_W        = 16;
	localparam int DISP_SHIFT    = 9;

	localparam logic [DEPTH_W-1:0] DEPTH_LO_RST = 8'd2;
	localparam logic [DEPTH_W-1:0] DEPTH_HI_RST = 8'd60;
	localparam logic [DISP_W-1:0]  DISP_SAT     = 16'hFFFF;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic REG_DEPTH_LO = 1'b0;
	localparam logic REG_DEPTH_HI = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [COL_W-1:0]   column;
		logic [DEPTH_W-1:0] depth_label;
	} in_t;

	typedef struct packed {
		logic [DISP_W-1:0] disparity;
		logic              pixel_set;
	} out_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth_lo;
		logic [DEPTH_W-1:0] depth_hi;
	} cfg_t;

endpackage

// ===== rtl/core/gdd_row_mem.sv =====
// Row depth store: one write port, one synchronous read port.
module gdd_row_mem
	import gdd_pkg::*;
#(
	parameter int DEPTH = ROW_WIDTH_DEF,
	parameter int AW    = $clog2(ROW_WIDTH_DEF)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [DEPTH_W-1:0] wdata,
	input  logic [AW-1:0]      raddr,
	output logic [DEPTH_W-1:0] rdata
);

	logic [DEPTH_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/gdd_scan.sv =====
// Request sequencer: label loads, pipelined downward depth scan, result register.
module gdd_scan
	import gdd_pkg::*;
#(
	parameter int ROW_WIDTH = ROW_WIDTH_DEF,
	parameter int AW        = $clog2(ROW_WIDTH_DEF)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_t                in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output out_t               out_data,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output logic [DEPTH_W-1:0] mem_wdata,
	output logic [AW-1:0]      mem_raddr,
	input  logic [DEPTH_W-1:0] mem_rdata
);

	localparam int CW = ((AW > COL_W) ? AW : COL_W) + 1;

	typedef enum logic [1:0] {IDLE, SCAN, DONE} state_t;

	state_t             state_q;
	logic               issue_q;
	logic               vld_s1;
	logic               found_q;
	logic [DEPTH_W-1:0] d_q;
	logic [DEPTH_W-1:0] d_s1;
	logic               ok_s1;
	logic               last_s1;
	logic [DEPTH_W-1:0] fd_q;
	logic [COL_W-1:0]   col_q;
	logic [CW-1:0]      col_in_w;
	logic [CW-1:0]      rd_diff;
	logic               in_row;
	logic               accept;
	logic [DEPTH_W:0]   load_sum;
	logic               match;
	logic               slot_free;
	logic               issue_now;
	logic               res_load;
	logic               res_set;
	logic [DISP_W-1:0]  res_dis;

	assign in_ready  = (state_q == IDLE);
	assign accept    = in_valid && in_ready;
	assign col_in_w  = CW'(in_data.column);
	assign in_row    = col_in_w < CW'(ROW_WIDTH);
	assign load_sum  = {1'b0, in_data.depth_label} + {1'b0, cfg.depth_lo};

	assign mem_we    = accept && (in_data.mode == MODE_LOAD) && in_row;
	assign mem_waddr = col_in_w[AW-1:0];
	assign mem_wdata = load_sum[DEPTH_W] ? {DEPTH_W{1'b1}} : load_sum[DEPTH_W-1:0];

	assign rd_diff   = CW'(col_q) - CW'(d_q);
	assign mem_raddr = rd_diff[AW-1:0];

	assign match     = vld_s1 && ok_s1 && (mem_rdata >= d_s1);
	assign slot_free = !out_valid || out_ready;

	// Issue the next read unless the scan has just ended
	assign issue_now = (state_q == SCAN) && issue_q && !match && !(vld_s1 && last_s1);
	assign res_load  = (state_q == DONE) && slot_free;

	// Margin test and scaled depth, saturated once the depth reaches 128
	always_comb begin
		res_set = found_q && ({1'b0, col_q} >= {3'b000, cfg.depth_lo, 1'b0});
		res_dis = '0;
		if (res_set) begin
			if (fd_q[DEPTH_W-1]) begin
				res_dis = DISP_SAT;
			end else begin
				res_dis = {fd_q[DEPTH_W-2:0], {DISP_SHIFT{1'b0}}};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			issue_q   <= 1'b0;
			vld_s1    <= 1'b0;
			found_q   <= 1'b0;
			out_valid <= 1'b0;
			out_data  <= '0;
		end else begin
			vld_s1    <= issue_now;
			out_valid <= res_load || (out_valid && !out_ready);
			if (res_load) begin
				out_data.disparity <= res_dis;
				out_data.pixel_set <= res_set;
			end
			case (state_q)
				IDLE: begin
					if (accept && (in_data.mode == MODE_QUERY)) begin
						found_q <= 1'b0;
						if (in_row && (cfg.depth_hi >= cfg.depth_lo)) begin
							state_q <= SCAN;
							issue_q <= 1'b1;
						end else begin
							state_q <= DONE;
						end
					end
				end
				SCAN: begin
					if (match) begin
						found_q <= 1'b1;
						issue_q <= 1'b0;
						state_q <= DONE;
					end else if (vld_s1 && last_s1) begin
						state_q <= DONE;
					end else if (issue_q && (d_q == cfg.depth_lo)) begin
						issue_q <= 1'b0;
					end
				end
				DONE: begin
					if (slot_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	// Payload: query column, scan depth and its tag, found depth
	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= in_data.column;
			d_q   <= cfg.depth_hi;
		end else if (state_q == SCAN && issue_q) begin
			d_q <= d_q - 1'b1;
		end
		if (state_q == SCAN && issue_q) begin
			d_s1    <= d_q;
			ok_s1   <= {1'b0, col_q} >= {4'd0, d_q};
			last_s1 <= (d_q == cfg.depth_lo);
		end
		if (match) begin
			fd_q <= d_s1;
		end
	end

endmodule

// ===== rtl/core/gaze_depth_to_disparity.sv =====
// Top level of the gaze depth to disparity converter for one image row.
// Input requests carry mode, column and depth_label over in_valid/in_ready.
// A load request (mode 0) stores the label plus the lower depth bound, saturated
// at 255, at its column in the row store at the edge it is taken; it yields no
// result, and the next request may follow in the next cycle. A query request
// (mode 1) scans depth from the upper bound down to the lower bound, one row
// store read per cycle, and yields one result (disparity, pixel_set) over
// out_valid/out_ready.
// Query result: out_valid rises after the scan reaches the lower bound when no
// depth matches, sooner on an early match; queries outside the row or with an
// empty range go straight to the DONE state, from which out_valid is registered.
// in_ready returns together with out_valid, so a query occupies the block until
// its result is registered; the row store's single read port serializes the scan.
// Configuration: cfg_write with cfg_index and cfg_data writes the lower depth
// bound (index 0) or the upper bound (index 1). The user must write one only while
// no request is in flight; the block itself does not enforce this. Reset sets the
// bounds to 2 and 60; the row store is undefined until each column is loaded. A
// stalled receiver holds the result in the output register; loads are still taken
// and one more query is scanned, keeping in_ready low until the register frees.
module gaze_depth_to_disparity
	import gdd_pkg::*;
#(
	parameter int ROW_WIDTH = ROW_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [DEPTH_W-1:0] cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_t                in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output out_t               out_data
);

	localparam int AW = $clog2(ROW_WIDTH);

	cfg_t               cfg_q;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [DEPTH_W-1:0] mem_wdata;
	logic [AW-1:0]      mem_raddr;
	logic [DEPTH_W-1:0] mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.depth_lo <= DEPTH_LO_RST;
			cfg_q.depth_hi <= DEPTH_HI_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_DEPTH_LO: cfg_q.depth_lo <= cfg_data;
				REG_DEPTH_HI: cfg_q.depth_hi <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	gdd_scan #(
		.ROW_WIDTH (ROW_WIDTH),
		.AW        (AW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	gdd_row_mem #(
		.DEPTH (ROW_WIDTH),
		.AW    (AW)
	) u_row_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
